// ===== hw/rtl/pkcd_pkg.sv =====
// shared constants and types for the per-key cooldown table
package pkcd_pkg;

   localparam int TIME_W = 32;
   localparam int ADDR_W = 32;
   localparam int DEF_TABLE_SLOTS = 64;
   localparam int DEF_KEY_BITS = 32;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [ADDR_W-1:0] addr_type;

   // default cooldown of twenty minutes
   localparam time_type PERIOD_RESET = time_type'(20 * 60);

endpackage

// ===== hw/rtl/per_key_cooldown_table_unit.sv =====
// top level: cooldown table over a rotating ring of slot cells
//
// Request channel (req_valid, req_stall, req_address_key, req_now_seconds)
// carries one word per lookup. The single result word on the rsp channel
// (rsp_valid, rsp_stall, rsp_report_allowed) says whether the key was
// allowed (absent, or last allowed at least csr period seconds ago).
// The slots sit in a ring of TABLE_SLOTS cells that rotates one place per
// cycle while a request scans or evicts; the head cell is compared against
// the request. A hit or an append takes one full turn of the ring in the
// scan state; the result state then registers the result word. A miss on a
// full table needs a second turn, in the evict state, to drop the oldest
// slot and append the new key before the result state. One request is in
// flight at a time, so the rate is set by the ring turns; req_stall is high
// while a request works.
// A result held by rsp_stall keeps the block from taking the next request
// only once that next result is ready. Reset (synchronous, active high)
// empties the table and loads the period with 1200; the csr write port may
// change the period while no request is in flight.
module per_key_cooldown_table_unit #(
   parameter int TABLE_SLOTS = pkcd_pkg::DEF_TABLE_SLOTS,
   parameter int KEY_BITS    = pkcd_pkg::DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pkcd_pkg::addr_type req_address_key,
   input  pkcd_pkg::time_type req_now_seconds,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_report_allowed,
   input  logic               csr_wr_en,
   input  pkcd_pkg::time_type csr_wr_data
);
   import pkcd_pkg::*;

   localparam int CNT_W    = $clog2(TABLE_SLOTS + 1);
   localparam int NEXT_IDX = (TABLE_SLOTS > 1) ? 1 : 0;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TABLE_SLOTS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_SLOTS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_EVICT = 2'd2;
   localparam logic [1:0] ST_RESP  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    victim_ff, victim_in;
   logic                found_ff, found_in;
   logic                result_ff, result_in;
   logic [KEY_BITS-1:0] key_ff;
   time_type            now_ff;
   time_type            min_ff, min_in;
   time_type            period_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_allowed_ff, rsp_allowed_in;

   logic [KEY_BITS-1:0] cell_key [TABLE_SLOTS];
   time_type            cell_time [TABLE_SLOTS];
   logic [KEY_BITS-1:0] fb_key;
   time_type            fb_time;
   logic                shift_en;

   logic [KEY_BITS+ADDR_W-1:0] key_wide;
   logic                req_take;
   logic                in_list, hit, ok, append, last, before_victim;
   logic                rsp_free;
   time_type            elapsed;

   assign key_wide = {{KEY_BITS{1'b0}}, req_address_key};
   assign req_take = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign shift_en = (state_ff == ST_SCAN) || (state_ff == ST_EVICT);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // slot ring, head is cell 0
   for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
      if (g == TABLE_SLOTS - 1) begin : g_tail
         pkcd_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .in_key   (fb_key),
            .in_time  (fb_time),
            .out_key  (cell_key[g]),
            .out_time (cell_time[g])
         );
      end else begin : g_body
         pkcd_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .in_key   (cell_key[g+1]),
            .in_time  (cell_time[g+1]),
            .out_key  (cell_key[g]),
            .out_time (cell_time[g])
         );
      end
   end

   assign in_list       = step_ff < fill_ff;
   assign elapsed       = now_ff - cell_time[0];
   assign ok            = elapsed >= period_ff;
   assign hit           = (state_ff == ST_SCAN) && in_list && !found_ff
                          && (cell_key[0] == key_ff);
   assign append        = (state_ff == ST_SCAN) && !found_ff && (step_ff == fill_ff);
   assign last          = step_ff == LAST_STEP;
   assign before_victim = step_ff < victim_ff;

   // value written back into the tail cell
   always_comb begin
      fb_key  = cell_key[0];
      fb_time = cell_time[0];
      if (state_ff == ST_SCAN) begin
         if (hit && ok) begin
            fb_time = now_ff;
         end else if (append) begin
            fb_key  = key_ff;
            fb_time = now_ff;
         end
      end else if (state_ff == ST_EVICT) begin
         if (last) begin
            fb_key  = key_ff;
            fb_time = now_ff;
         end else if (!before_victim) begin
            fb_key  = cell_key[NEXT_IDX];
            fb_time = cell_time[NEXT_IDX];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      fill_in        = fill_ff;
      victim_in      = victim_ff;
      found_in       = found_ff;
      result_in      = result_ff;
      min_in         = min_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_allowed_in = rsp_allowed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               step_in  = '0;
               found_in = 1'b0;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (hit) begin
               found_in  = 1'b1;
               result_in = ok;
            end
            if (in_list && ((step_ff == '0) || (cell_time[0] < min_ff))) begin
               min_in    = cell_time[0];
               victim_in = step_ff;
            end
            if (last) begin
               step_in = '0;
               if (found_ff || hit) begin
                  state_in = ST_RESP;
               end else if (fill_ff != FULL_CNT) begin
                  fill_in   = fill_ff + 1'b1;
                  result_in = 1'b1;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_EVICT;
               end
            end
         end
         ST_EVICT: begin
            step_in = step_ff + 1'b1;
            if (last) begin
               step_in   = '0;
               result_in = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      victim_ff      <= victim_in;
      result_ff      <= result_in;
      min_ff         <= min_in;
      rsp_allowed_ff <= rsp_allowed_in;
      if (req_take) begin
         key_ff <= key_wide[KEY_BITS-1:0];
         now_ff <= req_now_seconds;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_report_allowed = rsp_allowed_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count beyond table size");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (fill_ff != $past(fill_ff))) |-> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("fill count moved by other than one");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) |-> (fill_ff == FULL_CNT))
      else $error("eviction pass on a table that is not full");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == ST_RESP))
      else $error("result word raised outside the result state");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      shift_en |-> (step_ff <= LAST_STEP))
      else $error("ring step beyond last cell");

endmodule

// ===== hw/rtl/pkcd_cell.sv =====
// one storage cell of the rotating slot ring
module pkcd_cell #(
   parameter int KEY_BITS = pkcd_pkg::DEF_KEY_BITS
) (
   input  logic               clock,
   input  logic               shift_en,
   input  logic [KEY_BITS-1:0] in_key,
   input  pkcd_pkg::time_type in_time,
   output logic [KEY_BITS-1:0] out_key,
   output pkcd_pkg::time_type out_time
);
   import pkcd_pkg::*;

   logic [KEY_BITS-1:0] key_ff;
   time_type            time_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         key_ff  <= in_key;
         time_ff <= in_time;
      end
   end

   assign out_key  = key_ff;
   assign out_time = time_ff;

endmodule
